/* rtl/cfl_pkg.sv */
`default_nettype none

package cfl_pkg;

  // Item kinds carried on the action field
  typedef enum logic [1:0] {
    ActCheck   = 2'd0,
    ActTrigger = 2'd1,
    ActClear   = 2'd2,
    ActUnused  = 2'd3
  } action_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CfgVoltageMax  = 3'd0,
    CfgVoltageMin  = 3'd1,
    CfgCurrentMax  = 3'd2,
    CfgCurrentWarn = 3'd3,
    CfgTempShut    = 3'd4,
    CfgCooldown    = 3'd5,
    CfgUvDelay     = 3'd6,
    CfgFeatures    = 3'd7
  } cfg_idx_e;

  // Fault codes
  localparam logic [7:0] CodeNone      = 8'h00;
  localparam logic [7:0] CodeTemp      = 8'h01;
  localparam logic [7:0] CodeCurrent   = 8'h02;
  localparam logic [7:0] CodeOverVolt  = 8'h03;
  localparam logic [7:0] CodeUnderVolt = 8'h04;
  localparam logic [7:0] CodeRipple    = 8'h05;

  // Feature mask bits
  localparam int unsigned FeatInputUv  = 0;
  localparam int unsigned FeatRipple   = 1;
  localparam int unsigned FeatRecovery = 2;

  // Recovery hysteresis
  localparam logic [16:0] UvHystMv   = 17'd200;
  localparam logic [12:0] TempHystDc = 13'sd100;

  // Configuration register reset values
  localparam logic [15:0] VoltageMaxRst  = 16'd60000;
  localparam logic [15:0] VoltageMinRst  = 16'd1000;
  localparam logic [14:0] CurrentMaxRst  = 15'd10000;
  localparam logic [14:0] CurrentWarnRst = 15'd8000;
  localparam logic [11:0] TempShutRst    = 12'd850;
  localparam logic [31:0] CooldownRst    = 32'd5000;
  localparam logic [31:0] UvDelayRst     = 32'd500;
  localparam logic [2:0]  FeaturesRst    = 3'd4;

  typedef struct packed {
    logic [15:0]        voltage_max_mv;
    logic [15:0]        voltage_min_mv;
    logic [14:0]        current_max_ma;
    logic [14:0]        current_warning_ma;
    logic signed [11:0] temp_shutdown_dc;
    logic [31:0]        cooldown_ms;
    logic [31:0]        uv_delay_ms;
    logic [2:0]         feature_mask;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [31:0]        now_ms;
    logic               meas_valid;
    logic [15:0]        vin_mv;
    logic [15:0]        vout_mv;
    logic signed [15:0] current_ma;
    logic signed [11:0] temp_dc;
    logic               pwm_running;
    logic               ripple_valid;
    logic [15:0]        ripple_ma;
    logic [7:0]         trigger_code;
  } item_t;

  typedef struct packed {
    logic        latch_flag;
    logic [7:0]  held_code;
    logic [31:0] latch_time;
    logic [31:0] run_start_time;
    logic        run_start_known;
    logic        error_state;
  } state_t;

  typedef struct packed {
    logic       fault_latched;
    logic [7:0] fault_code;
    logic       emergency_stop;
    logic       newly_latched;
    logic       system_error;
    logic       recovered;
    logic       integ_reset;
  } result_t;

endpackage

`default_nettype wire

/* rtl/converter_fault_latch.sv */
// Converter protection latch.
// Input channel (in_valid_i / in_ready_o) carries one item: a safety check
// with one measurement, an external fault trigger, or a clear. Output channel
// (out_valid_o / out_ready_i) returns exactly one result per item: latch
// state, held fault code, error state and the stop / recovery / regulator
// reset pulses. Configuration registers are written through the cfg channel
// (cfg_valid_i / cfg_ready_o, always ready); the user must write them only
// while no item is in flight, which the block itself does not enforce.
// An accepted item is held in the input register and evaluated there; when
// the output register is free, the latch state is updated and the result is
// loaded into the output register at the same edge, from where it transfers.
// The block takes one item per cycle while the receiver takes every result,
// as the latch state is evaluated and updated combinationally in one step.
// When the receiver stalls, the result holds in the output register and the
// input register takes one more item, then in_ready_o drops until the
// result is taken.
// Reset clears the latch state, the run-time tracking and the valid flags of
// both pipeline registers, and loads the configuration defaults.
`default_nettype none

module converter_fault_latch import cfl_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration write channel
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  // input item channel
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         action_i,
  input  wire logic [31:0]        now_ms_i,
  input  wire logic               meas_valid_i,
  input  wire logic [15:0]        vin_mv_i,
  input  wire logic [15:0]        vout_mv_i,
  input  wire logic signed [15:0] current_ma_i,
  input  wire logic signed [11:0] temp_dc_i,
  input  wire logic               pwm_running_i,
  input  wire logic               ripple_valid_i,
  input  wire logic [15:0]        ripple_ma_i,
  input  wire logic [7:0]         trigger_code_i,
  // result channel
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    fault_latched_o,
  output logic [7:0]              fault_code_o,
  output logic                    emergency_stop_o,
  output logic                    newly_latched_o,
  output logic                    system_error_o,
  output logic                    recovered_o,
  output logic                    integ_reset_o
);

  cfg_t    cfg_q;
  item_t   item_q;
  logic    item_valid_q;
  state_t  state_q, state_d;
  result_t res_q, res_d;
  logic    out_valid_q;
  logic    advance;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.voltage_max_mv     <= VoltageMaxRst;
      cfg_q.voltage_min_mv     <= VoltageMinRst;
      cfg_q.current_max_ma     <= CurrentMaxRst;
      cfg_q.current_warning_ma <= CurrentWarnRst;
      cfg_q.temp_shutdown_dc   <= TempShutRst;
      cfg_q.cooldown_ms        <= CooldownRst;
      cfg_q.uv_delay_ms        <= UvDelayRst;
      cfg_q.feature_mask       <= FeaturesRst;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgVoltageMax:  cfg_q.voltage_max_mv     <= cfg_data_i[15:0];
        CfgVoltageMin:  cfg_q.voltage_min_mv     <= cfg_data_i[15:0];
        CfgCurrentMax:  cfg_q.current_max_ma     <= cfg_data_i[14:0];
        CfgCurrentWarn: cfg_q.current_warning_ma <= cfg_data_i[14:0];
        CfgTempShut:    cfg_q.temp_shutdown_dc   <= cfg_data_i[11:0];
        CfgCooldown:    cfg_q.cooldown_ms        <= cfg_data_i;
        CfgUvDelay:     cfg_q.uv_delay_ms        <= cfg_data_i;
        CfgFeatures:    cfg_q.feature_mask       <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // Evaluate the held item when the result register is free
  assign advance    = item_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q.action       <= action_i;
      item_q.now_ms       <= now_ms_i;
      item_q.meas_valid   <= meas_valid_i;
      item_q.vin_mv       <= vin_mv_i;
      item_q.vout_mv      <= vout_mv_i;
      item_q.current_ma   <= current_ma_i;
      item_q.temp_dc      <= temp_dc_i;
      item_q.pwm_running  <= pwm_running_i;
      item_q.ripple_valid <= ripple_valid_i;
      item_q.ripple_ma    <= ripple_ma_i;
      item_q.trigger_code <= trigger_code_i;
    end
  end

  cfl_eval u_eval (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Latch state advances once per evaluated item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign fault_latched_o  = res_q.fault_latched;
  assign fault_code_o     = res_q.fault_code;
  assign emergency_stop_o = res_q.emergency_stop;
  assign newly_latched_o  = res_q.newly_latched;
  assign system_error_o   = res_q.system_error;
  assign recovered_o      = res_q.recovered;
  assign integ_reset_o    = res_q.integ_reset;

  // A held latch always comes with the error state
  a_latch_implies_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.latch_flag |-> state_q.error_state)
    else $error("latch set without error state");

  // A new latch reports a stop and a set latch
  a_newly_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.newly_latched) |-> (res_q.emergency_stop && res_q.fault_latched))
    else $error("newly latched without stop or latch");

  // Recovery leaves latch and error cleared and resets the regulator
  a_recover_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.recovered) |->
      (res_q.integ_reset && !res_q.fault_latched && !res_q.system_error))
    else $error("recovery result inconsistent");

  // Input stalls only while an item is held and the result is blocked
  a_stall_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (item_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without cause");

endmodule

`default_nettype wire

/* rtl/cfl_eval.sv */
`default_nettype none

module cfl_eval import cfl_pkg::*; (
  input  cfg_t    cfg_i,
  input  state_t  state_i,
  input  item_t   item_i,
  output state_t  state_o,
  output result_t result_o
);

  logic        [16:0] abs_cur;
  logic        [31:0] run_start;
  logic               run_known;
  logic               uv_armed;
  logic               fault;
  logic        [7:0]  code;
  logic               healthy;
  logic               cooled;
  logic               estop;
  logic               newly;
  logic               recov;
  logic               pidr;
  logic        [16:0] vin_floor;
  logic signed [12:0] temp_floor;
  state_t             nxt;

  // Magnitude of the current, one bit wider to hold the most negative value
  assign abs_cur = item_i.current_ma[15] ? (17'd0 - {item_i.current_ma[15], item_i.current_ma})
                                         : {1'b0, item_i.current_ma};

  // Track when PWM started running
  always_comb begin
    run_start = state_i.run_start_time;
    run_known = state_i.run_start_known;
    if (item_i.pwm_running && !state_i.run_start_known) begin
      run_start = item_i.now_ms;
      run_known = 1'b1;
    end
    if (!item_i.pwm_running) begin
      run_known = 1'b0;
    end
  end

  assign uv_armed = item_i.pwm_running && run_known &&
                    ((item_i.now_ms - run_start) >= cfg_i.uv_delay_ms);

  // Fault causes, highest priority last
  always_comb begin
    fault = 1'b0;
    code  = CodeNone;
    if (item_i.temp_dc > cfg_i.temp_shutdown_dc) begin
      fault = 1'b1;
      code  = CodeTemp;
    end
    if (abs_cur > {2'b00, cfg_i.current_max_ma}) begin
      fault = 1'b1;
      code  = CodeCurrent;
    end
    if ((item_i.vin_mv > cfg_i.voltage_max_mv) || (item_i.vout_mv > cfg_i.voltage_max_mv)) begin
      fault = 1'b1;
      code  = CodeOverVolt;
    end
    if (cfg_i.feature_mask[FeatInputUv] && (item_i.vin_mv < cfg_i.voltage_min_mv)) begin
      fault = 1'b1;
      code  = CodeUnderVolt;
    end
    if (uv_armed && (item_i.vout_mv < cfg_i.voltage_min_mv)) begin
      fault = 1'b1;
      code  = CodeUnderVolt;
    end
    if (cfg_i.feature_mask[FeatRipple] && item_i.ripple_valid &&
        ({item_i.ripple_ma, 1'b0} > {2'b00, cfg_i.current_max_ma})) begin
      fault = 1'b1;
      code  = CodeRipple;
    end
  end

  // Recovery conditions with hysteresis
  assign vin_floor  = {1'b0, cfg_i.voltage_min_mv} + UvHystMv;
  assign temp_floor = {cfg_i.temp_shutdown_dc[11], cfg_i.temp_shutdown_dc} - TempHystDc;
  assign healthy = ({1'b0, item_i.vin_mv} >= vin_floor) &&
                   (item_i.vin_mv <= cfg_i.voltage_max_mv) &&
                   (item_i.vout_mv <= cfg_i.voltage_max_mv) &&
                   (abs_cur < {2'b00, cfg_i.current_warning_ma}) &&
                   ($signed({item_i.temp_dc[11], item_i.temp_dc}) < temp_floor);
  assign cooled = (item_i.now_ms - state_i.latch_time) >= cfg_i.cooldown_ms;

  // Next state and pulses
  always_comb begin
    nxt   = state_i;
    estop = 1'b0;
    newly = 1'b0;
    recov = 1'b0;
    pidr  = 1'b0;
    case (action_e'(item_i.action))
      ActCheck: begin
        nxt.run_start_time  = run_start;
        nxt.run_start_known = run_known;
        if (item_i.meas_valid) begin
          if (fault) begin
            estop           = 1'b1;
            nxt.error_state = 1'b1;
            nxt.latch_flag  = 1'b1;
            if (!state_i.latch_flag) begin
              nxt.held_code  = code;
              nxt.latch_time = item_i.now_ms;
              newly          = 1'b1;
            end
          end else if (cfg_i.feature_mask[FeatRecovery] && state_i.latch_flag &&
                       cooled && healthy) begin
            nxt.latch_flag  = 1'b0;
            nxt.held_code   = CodeNone;
            nxt.error_state = 1'b0;
            recov           = 1'b1;
            pidr            = 1'b1;
          end
        end
      end
      ActTrigger: begin
        nxt.error_state = 1'b1;
        nxt.held_code   = item_i.trigger_code;
        nxt.latch_flag  = 1'b1;
        nxt.latch_time  = item_i.now_ms;
        estop           = 1'b1;
      end
      ActClear: begin
        nxt.latch_flag = 1'b0;
        nxt.held_code  = CodeNone;
        nxt.latch_time = '0;
        pidr           = 1'b1;
      end
      default: begin
        nxt = state_i;
      end
    endcase
  end

  assign state_o                 = nxt;
  assign result_o.fault_latched  = nxt.latch_flag;
  assign result_o.fault_code     = nxt.held_code;
  assign result_o.emergency_stop = estop;
  assign result_o.newly_latched  = newly;
  assign result_o.system_error   = nxt.error_state;
  assign result_o.recovered      = recov;
  assign result_o.integ_reset    = pidr;

endmodule

`default_nettype wire

/* sim/tb_converter_fault_latch.sv */
module tb_converter_fault_latch import cfl_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam realtime ClkPeriod   = 20ns;
  localparam int      LimitCycles = 200_000;
  localparam int      DrainCycles = 4;
  localparam int      PhaseItems  = 290;
  localparam int      NumPhases   = 6;
  localparam int      RxHoldLen   = 300;

  typedef logic [31:0] reg_set_t [8];

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // Configuration channel
  logic       cfg_valid = 1'b0;
  cfg_idx_e   cfg_index = CfgVoltageMax;
  logic [31:0] cfg_data = '0;
  logic       cfg_ready;

  // Item and result channels
  logic  in_valid  = 1'b0;
  item_t drv_item  = '0;
  logic  in_ready;
  logic  out_ready = 1'b0;
  logic  out_valid;
  logic       fault_latched, emergency_stop, newly_latched;
  logic       system_error, recovered, integ_reset;
  logic [7:0] fault_code;

  // Stimulus feed and predicted latch reports
  item_t   item_feed_q[$];
  result_t report_q[$];
  bit      in_taken = 1'b0;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit rx_stall_req  = 1'b0;
  bit rx_stall_done = 1'b0;
  int rx_hold_left  = 0;
  int bad_reports   = 0;

  // Stimulus time base and PWM level
  logic [31:0] tick_ms   = 32'd0;
  bit          pwm_level = 1'b0;

  // Predictor copy of the registers
  logic [15:0]        cfg_vmax  = VoltageMaxRst;
  logic [15:0]        cfg_vmin  = VoltageMinRst;
  logic [14:0]        cfg_imax  = CurrentMaxRst;
  logic [14:0]        cfg_iwarn = CurrentWarnRst;
  logic signed [11:0] cfg_tshut = TempShutRst;
  logic [31:0]        cfg_cool  = CooldownRst;
  logic [31:0]        cfg_uvd   = UvDelayRst;
  logic [2:0]         cfg_feat  = FeaturesRst;

  // Predictor copy of the latch state
  logic        lat_flag  = 1'b0;
  logic [7:0]  lat_code  = CodeNone;
  logic [31:0] lat_time  = '0;
  logic [31:0] run_t0    = '0;
  logic        run_known = 1'b0;
  logic        err_state = 1'b0;

  converter_fault_latch dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .action_i         (drv_item.action),
    .now_ms_i         (drv_item.now_ms),
    .meas_valid_i     (drv_item.meas_valid),
    .vin_mv_i         (drv_item.vin_mv),
    .vout_mv_i        (drv_item.vout_mv),
    .current_ma_i     (drv_item.current_ma),
    .temp_dc_i        (drv_item.temp_dc),
    .pwm_running_i    (drv_item.pwm_running),
    .ripple_valid_i   (drv_item.ripple_valid),
    .ripple_ma_i      (drv_item.ripple_ma),
    .trigger_code_i   (drv_item.trigger_code),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .fault_latched_o  (fault_latched),
    .fault_code_o     (fault_code),
    .emergency_stop_o (emergency_stop),
    .newly_latched_o  (newly_latched),
    .system_error_o   (system_error),
    .recovered_o      (recovered),
    .integ_reset_o    (integ_reset)
  );

  initial begin
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  // Update the register copy on a config transfer
  function automatic void apply_reg(cfg_idx_e idx, logic [31:0] d);
    case (idx)
      CfgVoltageMax:  cfg_vmax  = d[15:0];
      CfgVoltageMin:  cfg_vmin  = d[15:0];
      CfgCurrentMax:  cfg_imax  = d[14:0];
      CfgCurrentWarn: cfg_iwarn = d[14:0];
      CfgTempShut:    cfg_tshut = d[11:0];
      CfgCooldown:    cfg_cool  = d;
      CfgUvDelay:     cfg_uvd   = d;
      CfgFeatures:    cfg_feat  = d[2:0];
      default: ;
    endcase
  endfunction

  // Evaluate one item against the latch state and return its report
  function automatic result_t predict_latch(item_t it);
    result_t     r;
    int          vin, vout, cur, acur, temp, tshut;
    logic        fault, healthy;
    logic [7:0]  code;
    logic [31:0] run_age, lat_age;
    r     = '0;
    vin   = int'(it.vin_mv);
    vout  = int'(it.vout_mv);
    cur   = int'($signed(it.current_ma));
    temp  = int'($signed(it.temp_dc));
    tshut = int'(cfg_tshut);
    case (action_e'(it.action))
      ActCheck: begin
        // Track PWM run start for output under-voltage arming
        if (it.pwm_running && !run_known) begin
          run_t0    = it.now_ms;
          run_known = 1'b1;
        end
        if (!it.pwm_running) run_known = 1'b0;
        if (it.meas_valid) begin
          acur    = (cur < 0) ? -cur : cur;
          fault   = 1'b0;
          code    = CodeNone;
          run_age = it.now_ms - run_t0;
          lat_age = it.now_ms - lat_time;
          // Later causes override earlier ones
          if (temp > tshut) begin
            fault = 1'b1;
            code  = CodeTemp;
          end
          if (acur > int'(cfg_imax)) begin
            fault = 1'b1;
            code  = CodeCurrent;
          end
          if (vin > int'(cfg_vmax) || vout > int'(cfg_vmax)) begin
            fault = 1'b1;
            code  = CodeOverVolt;
          end
          if (cfg_feat[FeatInputUv] && vin < int'(cfg_vmin)) begin
            fault = 1'b1;
            code  = CodeUnderVolt;
          end
          if (it.pwm_running && run_known && run_age >= cfg_uvd &&
              vout < int'(cfg_vmin)) begin
            fault = 1'b1;
            code  = CodeUnderVolt;
          end
          if (cfg_feat[FeatRipple] && it.ripple_valid &&
              2 * int'(it.ripple_ma) > int'(cfg_imax)) begin
            fault = 1'b1;
            code  = CodeRipple;
          end
          if (fault) begin
            r.emergency_stop = 1'b1;
            err_state        = 1'b1;
            if (!lat_flag) begin
              lat_code        = code;
              lat_time        = it.now_ms;
              r.newly_latched = 1'b1;
            end
            lat_flag = 1'b1;
          end else if (cfg_feat[FeatRecovery] && lat_flag && lat_age >= cfg_cool) begin
            healthy = vin >= int'(cfg_vmin) + int'(UvHystMv) &&
                      vin <= int'(cfg_vmax) && vout <= int'(cfg_vmax) &&
                      acur < int'(cfg_iwarn) &&
                      temp < tshut - int'(TempHystDc);
            if (healthy) begin
              lat_flag      = 1'b0;
              lat_code      = CodeNone;
              err_state     = 1'b0;
              r.recovered   = 1'b1;
              r.integ_reset = 1'b1;
            end
          end
        end
      end
      ActTrigger: begin
        err_state        = 1'b1;
        lat_code         = it.trigger_code;
        lat_flag         = 1'b1;
        lat_time         = it.now_ms;
        r.emergency_stop = 1'b1;
      end
      ActClear: begin
        lat_flag      = 1'b0;
        lat_code      = CodeNone;
        lat_time      = '0;
        r.integ_reset = 1'b1;
      end
      default: ;
    endcase
    r.fault_latched = lat_flag;
    r.fault_code    = lat_code;
    r.system_error  = err_state;
    return r;
  endfunction

  // Quiet check item; directed cases tweak fields from here
  function automatic item_t calm(logic [31:0] now, logic pwm);
    item_t it;
    it              = '0;
    it.action       = ActCheck;
    it.now_ms       = now;
    it.meas_valid   = 1'b1;
    it.vin_mv       = 16'd12000;
    it.vout_mv      = 16'd5000;
    it.current_ma   = 16'sd100;
    it.temp_dc      = 12'sd250;
    it.pwm_running  = pwm;
    return it;
  endfunction

  // Value from the healthy band, near a limit, or over the full range
  function automatic int pick(int lo, int hi, int edge_v, int ok_lo, int ok_hi);
    int r, v;
    r = $urandom_range(0, 99);
    if (r < 60 && ok_lo <= ok_hi) v = ok_lo + int'($urandom_range(0, ok_hi - ok_lo));
    else if (r < 85) v = edge_v + int'($urandom_range(0, 6)) - 3;
    else v = lo + int'($urandom_range(0, hi - lo));
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  function automatic item_t rand_item();
    item_t it;
    int    r, mag, vmin, vmax, imax, iwarn, tshut, thys;
    vmin  = int'(cfg_vmin);
    vmax  = int'(cfg_vmax);
    imax  = int'(cfg_imax);
    iwarn = int'(cfg_iwarn);
    tshut = int'(cfg_tshut);
    thys  = int'(TempHystDc);
    // Advance time, with rare jumps that wrap the counter
    r = $urandom_range(0, 99);
    if (r < 3) tick_ms = $urandom();
    else if (r < 6) tick_ms += $urandom();
    else tick_ms += $urandom_range(0, 40);
    if ($urandom_range(0, 99) < 5) pwm_level = !pwm_level;
    r = $urandom_range(0, 99);
    it.action = (r < 78) ? ActCheck : (r < 87) ? ActClear : (r < 95) ? ActTrigger : ActUnused;
    it.now_ms      = tick_ms;
    it.meas_valid  = ($urandom_range(0, 9) != 0);
    it.vin_mv      = 16'(pick(0, 65535,
                         ($urandom_range(0, 2) == 0) ? vmax :
                         ($urandom_range(0, 1) != 0) ? vmin : vmin + int'(UvHystMv),
                         vmin + int'(UvHystMv), vmax));
    it.vout_mv     = 16'(pick(0, 65535, ($urandom_range(0, 1) != 0) ? vmax : vmin,
                              vmin, vmax));
    mag = pick(0, 32767, ($urandom_range(0, 1) != 0) ? imax : iwarn, 0, iwarn - 1);
    it.current_ma  = 16'(($urandom_range(0, 1) != 0) ? -mag : mag);
    if ($urandom_range(0, 9) == 0) it.current_ma = 16'($urandom());
    it.temp_dc     = 12'(pick(-550, 1500, ($urandom_range(0, 1) != 0) ? tshut : tshut - thys,
                              -550, tshut - thys - 1));
    it.pwm_running  = pwm_level;
    it.ripple_valid = 1'($urandom_range(0, 1));
    it.ripple_ma    = 16'(pick(0, 65535, imax / 2, 0, imax / 2));
    it.trigger_code = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic reg_set_t make_settings(int ph);
    reg_set_t s;
    int       imax;
    imax = $urandom_range(1000, 32767);
    case (ph)
      0: s = '{32'd50000, 32'd3000, 32'd6000, 32'd5000, 32'd600, 32'd40, 32'd30, 32'd7};
      1: s = '{32'd0, 32'd0, 32'd0, 32'd0, 32'(-550), 32'd0, 32'd0, 32'd7};
      2: s = '{32'd65535, 32'd65535, 32'd32767, 32'd32767, 32'd1500,
               32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0};
      3: s = '{32'($urandom_range(0, 65535)), 32'($urandom_range(0, 65535)),
               32'($urandom_range(0, 32767)), 32'($urandom_range(0, 32767)),
               32'(int'($urandom_range(0, 2050)) - 550), $urandom(), $urandom(),
               32'($urandom_range(0, 7))};
      default: s = '{32'($urandom_range(30000, 65535)), 32'($urandom_range(0, 20000)),
                     32'(imax), 32'($urandom_range(0, imax)),
                     32'(int'($urandom_range(0, 2050)) - 550),
                     32'($urandom_range(0, 300)), 32'($urandom_range(0, 300)),
                     32'($urandom_range(0, 7))};
    endcase
    return s;
  endfunction

  // Write all registers back to back; block is idle here
  task automatic load_settings(input reg_set_t s);
    for (int i = 0; i < 8; i++) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= cfg_idx_e'(i);
      cfg_data  <= s[i];
      do @(posedge clk); while (!cfg_ready);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every item is taken and every report has arrived
  task automatic wait_drain();
    while (item_feed_q.size() != 0 || in_valid || report_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Driver: hold an offered item until its transfer, then maybe offer the next
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (item_feed_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        drv_item <= item_feed_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure plus one long hold-off
  always @(negedge clk) begin
    if (rx_hold_left != 0) begin
      rx_hold_left = rx_hold_left - 1;
      out_ready <= 1'b0;
    end else if (rx_stall_req && !rx_stall_done) begin
      rx_stall_done = 1'b1;
      rx_hold_left  = RxHoldLen;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Monitor: compare results, track config writes, predict accepted items
  always @(posedge clk) begin
    result_t want, got;
    in_taken = 1'b0;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = {fault_latched, fault_code, emergency_stop, newly_latched,
               system_error, recovered, integ_reset};
        if (report_q.size() == 0) begin
          bad_reports++;
          if (bad_reports <= 10)
            $display("%0t: result with nothing pending: %p", $realtime, got);
        end else begin
          want = report_q.pop_front();
          if (got.fault_latched  !== want.fault_latched  ||
              got.fault_code     !== want.fault_code     ||
              got.emergency_stop !== want.emergency_stop ||
              got.newly_latched  !== want.newly_latched  ||
              got.system_error   !== want.system_error   ||
              got.recovered      !== want.recovered      ||
              got.integ_reset    !== want.integ_reset) begin
            bad_reports++;
            if (bad_reports <= 10)
              $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
          end
        end
      end
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        report_q.push_back(predict_latch(drv_item));
        in_taken = 1'b1;
      end
    end
  end

  initial begin
    #(LimitCycles * ClkPeriod);
    $display("converter_fault_latch verification failed");
    $finish;
  end

  initial begin
    item_t it;
    int    n;
    tx_idle_pct = 34;
    rx_idle_pct = 73;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed cases at reset settings
    item_feed_q.push_back(calm(32'd100, 1'b0));
    it = calm(32'd110, 1'b0); it.temp_dc = 12'sd851; item_feed_q.push_back(it);
    // second fault while latched keeps the first code
    it = calm(32'd120, 1'b0); it.current_ma = 16'sd10001; item_feed_q.push_back(it);
    it = calm(32'd130, 1'b0); it.action = ActClear; item_feed_q.push_back(it);
    it = calm(32'd140, 1'b0); it.current_ma = -16'sd10001; item_feed_q.push_back(it);
    it = calm(32'd150, 1'b0); it.action = ActClear; item_feed_q.push_back(it);
    it = calm(32'd160, 1'b0); it.current_ma = 16'h8000; item_feed_q.push_back(it);
    it = calm(32'd170, 1'b0); it.action = ActClear; item_feed_q.push_back(it);
    it = calm(32'd180, 1'b0); it.vin_mv = 16'd65535; item_feed_q.push_back(it);
    it = calm(32'd190, 1'b0); it.action = ActClear; item_feed_q.push_back(it);
    it = calm(32'd200, 1'b0); it.vout_mv = 16'd60001; item_feed_q.push_back(it);
    it = calm(32'd210, 1'b0); it.action = ActClear; item_feed_q.push_back(it);
    // all causes at once: over-voltage wins
    it = calm(32'd220, 1'b0);
    it.temp_dc = 12'sd1500; it.current_ma = 16'sd32767; it.vin_mv = 16'd65535;
    item_feed_q.push_back(it);
    it = calm(32'd230, 1'b0); it.action = ActClear; item_feed_q.push_back(it);
    // output under-voltage arms only after the run delay
    item_feed_q.push_back(calm(32'd1000, 1'b1));
    it = calm(32'd1499, 1'b1); it.vout_mv = 16'd0; item_feed_q.push_back(it);
    it = calm(32'd1500, 1'b1); it.vout_mv = 16'd999; item_feed_q.push_back(it);
    it = calm(32'd1510, 1'b0); it.action = ActClear; item_feed_q.push_back(it);
    // no measurement still drops the run start
    it = calm(32'd1520, 1'b0); it.meas_valid = 1'b0; it.vin_mv = 16'd65535;
    item_feed_q.push_back(it);
    // triggers overwrite code and time, code zero included
    it = calm(32'd2000, 1'b0); it.action = ActTrigger; it.trigger_code = 8'd0;
    item_feed_q.push_back(it);
    it = calm(32'd2010, 1'b0); it.action = ActTrigger; it.trigger_code = 8'd255;
    item_feed_q.push_back(it);
    it = calm(32'd2020, 1'b0); it.action = ActClear; item_feed_q.push_back(it);
    it = calm(32'd2030, 1'b0); it.action = ActUnused; item_feed_q.push_back(it);
    // disabled input UV and ripple checks stay quiet
    it = calm(32'd2040, 1'b0);
    it.temp_dc = -12'sd550; it.vin_mv = 16'd0; it.ripple_valid = 1'b1; it.ripple_ma = 16'hFFFF;
    item_feed_q.push_back(it);
    // cooldown recovery with hysteresis
    it = calm(32'd10000, 1'b0); it.temp_dc = 12'sd900; item_feed_q.push_back(it);
    item_feed_q.push_back(calm(32'd14999, 1'b0));
    item_feed_q.push_back(calm(32'd15000, 1'b0));
    it = calm(32'd15010, 1'b0); it.current_ma = 16'sd9000; item_feed_q.push_back(it);
    wait_drain();

    // Random phases over several register settings
    tick_ms = 32'd20000;
    for (int ph = 0; ph < NumPhases; ph++) begin
      load_settings(make_settings(ph));
      if (ph < 2) begin
        tx_idle_pct = 34;
        rx_idle_pct = 73;
      end else if (ph < 4) begin
        tx_idle_pct = 73;
        rx_idle_pct = 34;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (ph == 4) rx_stall_req = 1'b1;
      n = 0;
      while (n < PhaseItems) begin
        it = rand_item();
        item_feed_q.push_back(it);
        n++;
      end
      wait_drain();
    end

    if (bad_reports == 0) begin
      $display("converter_fault_latch verification clean");
    end else begin
      $display("converter_fault_latch verification failed");
    end
    $finish;
  end

endmodule
